@@ design/spmd_pkg.sv @@
// Shared constants, codes and control structs for the signal dispatch block.
`timescale 1ns / 1ps

package spmd_pkg;

    localparam int NUM_SIGNALS = 64;
    localparam int IDX_W       = $clog2(NUM_SIGNALS);

    localparam logic [31:0] EINTR_NEG = 32'hFFFF_FFFC;

    // Command codes
    localparam logic [2:0] CMD_RAISE     = 3'd0;
    localparam logic [2:0] CMD_SET_MASK  = 3'd1;
    localparam logic [2:0] CMD_WRITE     = 3'd2;
    localparam logic [2:0] CMD_CHECK     = 3'd3;
    localparam logic [2:0] CMD_CHECK_INT = 3'd4;
    localparam logic [2:0] CMD_RETURN    = 3'd5;

    // Status codes
    localparam logic [2:0] ST_DONE        = 3'd0;
    localparam logic [2:0] ST_NONE        = 3'd1;
    localparam logic [2:0] ST_IN_HANDLER  = 3'd2;
    localparam logic [2:0] ST_NULL        = 3'd3;
    localparam logic [2:0] ST_NOT_HANDLER = 3'd4;
    localparam logic [2:0] ST_BAD_SIGNAL  = 3'd5;

    typedef struct packed {
        logic load;
        logic pick;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

@@ design/spmd_ctrl.sv @@
// Sequencer for the signal dispatch block: load, pick and commit steps.
`timescale 1ns / 1ps

module spmd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  spmd_pkg::dp_stat_t  stat,
    output spmd_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PICK = 3'b010,
        S_EVAL = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                // hold until the result register can take the new result
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ design/spmd_dp.sv @@
// Datapath: signal sets, handler memory, priority pick and result register.
`timescale 1ns / 1ps

module spmd_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  spmd_pkg::ctrl_cmd_t cmd,
    output spmd_pkg::dp_stat_t  stat,
    input  logic [2:0]          command,
    input  logic [6:0]          signal_number,
    input  logic [31:0]         address,
    input  logic                restart,
    input  logic [63:0]         mask_value,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [2:0]          status,
    output logic                dispatched,
    output logic [6:0]          chosen_signal,
    output logic [31:0]         handler_address,
    output logic [31:0]         resume_address,
    output logic                eax_written,
    output logic [31:0]         eax_value
);

    localparam int NS = spmd_pkg::NUM_SIGNALS;
    localparam int IW = spmd_pkg::IDX_W;

    // latched item
    logic [2:0]    cmd_reg;
    logic [6:0]    sig_reg;
    logic [31:0]   addr_reg;
    logic          restart_reg;
    logic [NS-1:0] mask_reg;

    // architectural state
    logic [NS-1:0] pending_reg;
    logic [NS-1:0] pending_next;
    logic [NS-1:0] blocked_reg;
    logic [NS-1:0] blocked_next;
    logic          in_handler_reg;
    logic          in_handler_next;
    logic [NS-1:0] entry_valid_reg;
    logic [NS-1:0] entry_valid_next;
    logic [32:0]   hmem [NS];

    // pick stage results
    logic          found_reg;
    logic [IW-1:0] idx_reg;
    logic [32:0]   rd_reg;
    logic          rd_valid_reg;

    // result register
    logic          out_valid_reg;
    logic [2:0]    status_reg;
    logic          dispatched_reg;
    logic [6:0]    chosen_reg;
    logic [31:0]   handler_reg;
    logic [31:0]   resume_reg;
    logic          eax_wr_reg;
    logic [31:0]   eax_val_reg;

    logic [NS-1:0] ready_set;
    logic          pick_found;
    logic [IW-1:0] pick_idx;
    logic [6:0]    sig_m1;
    logic [IW-1:0] sig_idx;
    logic          sig_ok;
    logic [31:0]   hnd;
    logic          hnd_restart;
    logic          mem_we;

    logic [2:0]    st_c;
    logic          disp_c;
    logic [6:0]    chosen_c;
    logic [31:0]   handler_c;
    logic [31:0]   resume_c;
    logic          eax_wr_c;
    logic [31:0]   eax_val_c;

    assign stat.out_free = !out_valid_reg || result_ready;

    // lowest pending, unblocked signal
    always_comb
    begin
        ready_set  = pending_reg & ~blocked_reg;
        pick_found = 1'b0;
        pick_idx   = '0;
        for (int i = NS - 1; i >= 0; i--)
        begin
            if (ready_set[i])
            begin
                pick_found = 1'b1;
                pick_idx   = IW'(i);
            end
        end
    end

    assign sig_m1  = sig_reg - 7'd1;
    assign sig_idx = sig_m1[IW-1:0];
    assign sig_ok  = (sig_reg != 7'd0) && (sig_reg <= 7'(NS));

    // an entry never written reads as a null handler without restart
    assign hnd         = rd_valid_reg ? rd_reg[31:0] : 32'd0;
    assign hnd_restart = rd_valid_reg & rd_reg[32];

    always_comb
    begin
        st_c             = spmd_pkg::ST_DONE;
        disp_c           = 1'b0;
        chosen_c         = 7'd0;
        handler_c        = 32'd0;
        resume_c         = 32'd0;
        eax_wr_c         = 1'b0;
        eax_val_c        = 32'd0;
        pending_next     = pending_reg;
        blocked_next     = blocked_reg;
        in_handler_next  = in_handler_reg;
        entry_valid_next = entry_valid_reg;
        mem_we           = 1'b0;
        unique case (cmd_reg) inside
            spmd_pkg::CMD_RAISE:
            begin
                if (!sig_ok)
                begin
                    st_c = spmd_pkg::ST_BAD_SIGNAL;
                end
                else
                begin
                    pending_next = pending_reg | (NS'(1) << sig_idx);
                end
            end
            spmd_pkg::CMD_SET_MASK:
            begin
                blocked_next = mask_reg;
            end
            spmd_pkg::CMD_WRITE:
            begin
                if (!sig_ok)
                begin
                    st_c = spmd_pkg::ST_BAD_SIGNAL;
                end
                else
                begin
                    mem_we                    = 1'b1;
                    entry_valid_next[sig_idx] = 1'b1;
                end
            end
            spmd_pkg::CMD_CHECK, spmd_pkg::CMD_CHECK_INT:
            begin
                if (in_handler_reg)
                begin
                    st_c = spmd_pkg::ST_IN_HANDLER;
                end
                else if (!found_reg)
                begin
                    st_c = spmd_pkg::ST_NONE;
                end
                else if (hnd == 32'd0)
                begin
                    st_c = spmd_pkg::ST_NULL;
                end
                else
                begin
                    disp_c    = 1'b1;
                    chosen_c  = 7'(idx_reg) + 7'd1;
                    handler_c = hnd;
                    resume_c  = addr_reg;
                    if (cmd_reg == spmd_pkg::CMD_CHECK_INT)
                    begin
                        if (hnd_restart)
                        begin
                            resume_c = addr_reg - 32'd2;
                        end
                        else
                        begin
                            eax_wr_c  = 1'b1;
                            eax_val_c = spmd_pkg::EINTR_NEG;
                        end
                    end
                    pending_next    = pending_reg & ~(NS'(1) << idx_reg);
                    in_handler_next = 1'b1;
                end
            end
            spmd_pkg::CMD_RETURN:
            begin
                if (!in_handler_reg)
                begin
                    st_c = spmd_pkg::ST_NOT_HANDLER;
                end
                else
                begin
                    in_handler_next = 1'b0;
                end
            end
            default:
            begin
                st_c = spmd_pkg::ST_DONE;
            end
        endcase
    end

    // item latch and pick results
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg     <= command;
            sig_reg     <= signal_number;
            addr_reg    <= address;
            restart_reg <= restart;
            mask_reg    <= mask_value[NS-1:0];
        end
        if (cmd.pick)
        begin
            found_reg    <= pick_found;
            idx_reg      <= pick_idx;
            rd_reg       <= hmem[pick_idx];
            rd_valid_reg <= entry_valid_reg[pick_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && mem_we)
        begin
            hmem[sig_idx] <= {restart_reg, addr_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg     <= '0;
            blocked_reg     <= '0;
            in_handler_reg  <= 1'b0;
            entry_valid_reg <= '0;
        end
        else if (cmd.commit)
        begin
            pending_reg     <= pending_next;
            blocked_reg     <= blocked_next;
            in_handler_reg  <= in_handler_next;
            entry_valid_reg <= entry_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg     <= st_c;
            dispatched_reg <= disp_c;
            chosen_reg     <= chosen_c;
            handler_reg    <= handler_c;
            resume_reg     <= resume_c;
            eax_wr_reg     <= eax_wr_c;
            eax_val_reg    <= eax_val_c;
        end
    end

    assign result_valid    = out_valid_reg;
    assign status          = status_reg;
    assign dispatched      = dispatched_reg;
    assign chosen_signal   = chosen_reg;
    assign handler_address = handler_reg;
    assign resume_address  = resume_reg;
    assign eax_written     = eax_wr_reg;
    assign eax_value       = eax_val_reg;

    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.commit))
        else $error("result appeared without a commit");

    a_dispatch_enters_handler: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && disp_c |=> in_handler_reg && !pending_reg[$past(idx_reg)])
        else $error("dispatch did not enter handler or clear pending bit");

    a_dispatch_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && dispatched_reg |->
            status_reg == spmd_pkg::ST_DONE && chosen_reg != 7'd0 && handler_reg != 32'd0)
        else $error("dispatched result with inconsistent fields");

endmodule

@@ design/signal_pending_mask_dispatch.sv @@
// Top level of the signal pending/mask dispatch block.
`timescale 1ns / 1ps

// Signal dispatch unit, used like a small interrupt controller.
// Input channel item_valid/item_ready carries one command per transfer:
// raise, set blocked mask, write handler, check, check after an
// interrupted call, or return from handler. Every command yields exactly
// one result transfer on result_valid/result_ready.
// Each item passes three steps from transfer to result: latching the item,
// the lowest-set-bit pick over the pending and unblocked signals together
// with the registered handler memory read, and evaluation, which updates
// state and loads the result register. The sequencer handles one item at
// a time and takes a new item only after the last one has been committed.
// If the receiver stalls, the result register holds its value and the next
// item is still taken and picked; it then waits in the evaluate step until
// the result register frees.
// Reset clears the pending set, the blocked mask, the in-handler flag and
// the per-entry valid bits; an entry never written reads as a null handler.
// No clearing pass is needed, so items are taken right after reset.
module signal_pending_mask_dispatch (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [2:0]  command,
    input  logic [6:0]  signal_number,
    input  logic [31:0] address,
    input  logic        restart,
    input  logic [63:0] mask_value,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  status,
    output logic        dispatched,
    output logic [6:0]  chosen_signal,
    output logic [31:0] handler_address,
    output logic [31:0] resume_address,
    output logic        eax_written,
    output logic [31:0] eax_value
);

    spmd_pkg::ctrl_cmd_t cmd;
    spmd_pkg::dp_stat_t  stat;

    spmd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    spmd_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .command         (command),
        .signal_number   (signal_number),
        .address         (address),
        .restart         (restart),
        .mask_value      (mask_value),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .status          (status),
        .dispatched      (dispatched),
        .chosen_signal   (chosen_signal),
        .handler_address (handler_address),
        .resume_address  (resume_address),
        .eax_written     (eax_written),
        .eax_value       (eax_value)
    );

endmodule
